// ===== src/leh_pkg.sv =====
package leh_pkg;

	localparam int CoordW = 6;

	typedef enum logic [2:0] {
		ST_MOVED       = 3'd0,
		ST_WALL        = 3'd1,
		ST_COLLIDED    = 3'd2,
		ST_BAD_PART    = 3'd3,
		ST_BAD_DIR     = 3'd4,
		ST_PLACED      = 3'd5,
		ST_PLACE_FAIL  = 3'd6
	} status_t;

	typedef enum logic [2:0] {
		REG_LATTICE_KIND    = 3'd0,
		REG_BOUNDARY_FIXED  = 3'd1,
		REG_SIDE_X          = 3'd2,
		REG_SIDE_Y          = 3'd3,
		REG_SIDE_Z          = 3'd4,
		REG_PARTICLE_COUNT  = 3'd5,
		REG_DIRECTION_COUNT = 3'd6
	} reg_index_t;

	typedef enum logic [2:0] {
		LK_SQUARE    = 3'd0,
		LK_HONEYCOMB = 3'd1,
		LK_BCC       = 3'd2,
		LK_FCC       = 3'd3,
		LK_LINE      = 3'd4
	} lattice_kind_t;

	// step deltas: 2-bit signed per axis
	localparam logic [1:0] DP = 2'b01;
	localparam logic [1:0] DN = 2'b11;
	localparam logic [1:0] D0 = 2'b00;

	typedef struct packed {
		logic clr;
		logic load;
		logic pos_rd;
		logic calc;
		logic occ_rd;
		logic commit;
		logic set_new;
	} cmd_t;

	typedef struct packed {
		logic out_free;
		logic need_set;
		logic clr_last;
	} sts_t;

	function automatic logic [4:0] step_count(input logic [2:0] kind);
		logic [4:0] n;
		n = 5'd0;
		unique case (kind)
			LK_SQUARE:    n = 5'd6;
			LK_HONEYCOMB: n = 5'd6;
			LK_BCC:       n = 5'd8;
			LK_FCC:       n = 5'd12;
			LK_LINE:      n = 5'd2;
			default:      n = 5'd0;
		endcase
		return n;
	endfunction

	// {dx, dy, dz}
	function automatic logic [5:0] step_lookup(input logic [2:0] kind, input logic [3:0] r);
		logic [5:0] s;
		s = {D0, D0, D0};
		unique case (kind)
			LK_SQUARE: begin
				unique case (r)
					4'd0: s = {DP, D0, D0};
					4'd1: s = {DN, D0, D0};
					4'd2: s = {D0, DP, D0};
					4'd3: s = {D0, DN, D0};
					4'd4: s = {D0, D0, DP};
					4'd5: s = {D0, D0, DN};
					default: s = {D0, D0, D0};
				endcase
			end
			LK_HONEYCOMB: begin
				unique case (r)
					4'd0: s = {DP, D0, D0};
					4'd1: s = {DN, D0, D0};
					4'd2: s = {D0, DP, D0};
					4'd3: s = {D0, DN, D0};
					4'd4: s = {DN, DP, D0};
					4'd5: s = {DP, DN, D0};
					default: s = {D0, D0, D0};
				endcase
			end
			LK_BCC: begin
				unique case (r)
					4'd0: s = {DP, DP, DP};
					4'd1: s = {DN, DP, DP};
					4'd2: s = {DP, DN, DP};
					4'd3: s = {DP, DP, DN};
					4'd4: s = {DP, DN, DN};
					4'd5: s = {DN, DP, DN};
					4'd6: s = {DN, DN, DP};
					4'd7: s = {DN, DN, DN};
					default: s = {D0, D0, D0};
				endcase
			end
			LK_FCC: begin
				unique case (r)
					4'd0:  s = {DP, DP, D0};
					4'd1:  s = {DN, DP, D0};
					4'd2:  s = {DP, DN, D0};
					4'd3:  s = {DN, DN, D0};
					4'd4:  s = {DP, D0, DP};
					4'd5:  s = {DP, D0, DN};
					4'd6:  s = {DN, D0, DP};
					4'd7:  s = {DN, D0, DN};
					4'd8:  s = {D0, DP, DP};
					4'd9:  s = {D0, DP, DN};
					4'd10: s = {D0, DN, DP};
					4'd11: s = {D0, DN, DN};
					default: s = {D0, D0, D0};
				endcase
			end
			LK_LINE: begin
				unique case (r)
					4'd0: s = {DP, D0, D0};
					4'd1: s = {DN, D0, D0};
					default: s = {D0, D0, D0};
				endcase
			end
			default: s = {D0, D0, D0};
		endcase
		return s;
	endfunction

endpackage

// ===== src/leh_ctrl.sv =====
module leh_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  leh_pkg::sts_t sts,
	output leh_pkg::cmd_t cmd
);
	import leh_pkg::*;

	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_RDPOS, S_CALC, S_RDOCC, S_DECIDE, S_SETNEW
	} state_t;

	state_t state_q;

	always_comb begin
		cmd         = '0;
		cmd.clr     = (state_q == S_CLEAR);
		cmd.load    = (state_q == S_IDLE) && in_valid;
		cmd.pos_rd  = (state_q == S_RDPOS);
		cmd.calc    = (state_q == S_CALC);
		cmd.occ_rd  = (state_q == S_RDOCC);
		cmd.commit  = (state_q == S_DECIDE) && sts.out_free;
		cmd.set_new = (state_q == S_SETNEW);
	end

	assign in_stall = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			unique case (state_q)
				S_CLEAR:  if (sts.clr_last) state_q <= S_IDLE;
				S_IDLE:   if (in_valid) state_q <= S_RDPOS;
				S_RDPOS:  state_q <= S_CALC;
				S_CALC:   state_q <= S_RDOCC;
				S_RDOCC:  state_q <= S_DECIDE;
				S_DECIDE: begin
					if (sts.out_free) state_q <= sts.need_set ? S_SETNEW : S_IDLE;
				end
				S_SETNEW: state_q <= S_IDLE;
				default:  state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== src/leh_datapath.sv =====
module leh_datapath #(
	parameter int MAX_SIDE      = 32,
	parameter int MAX_PARTICLES = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  leh_pkg::cmd_t       cmd,
	output leh_pkg::sts_t       sts,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [10:0]         cfg_data,
	input  logic                kind,
	input  logic [9:0]          particle,
	input  logic [3:0]          direction,
	input  logic [5:0]          place_x,
	input  logic [5:0]          place_y,
	input  logic [5:0]          place_z,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [2:0]          status,
	output logic [5:0]          site_x,
	output logic [5:0]          site_y,
	output logic [5:0]          site_z,
	output logic signed [31:0]  tag_dx,
	output logic signed [31:0]  tag_dy,
	output logic signed [31:0]  tag_dz
);
	import leh_pkg::*;

	localparam int AXW   = $clog2(MAX_SIDE);
	localparam int IW    = 3 * AXW;
	localparam int PW    = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
	localparam logic [6:0]  MS = 7'(MAX_SIDE);
	localparam logic [16:0] MP = 17'(MAX_PARTICLES);
	localparam logic signed [31:0] TMAX = 32'sh7fff_ffff;
	localparam logic signed [31:0] TMIN = 32'sh8000_0000;

	// configuration
	logic [2:0]  lat_kind_q;
	logic        fixed_q;
	logic [5:0]  side_x_q, side_y_q, side_z_q;
	logic [10:0] pcount_q;
	logic [3:0]  dcount_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lat_kind_q <= 3'd0;
			fixed_q    <= 1'b0;
			side_x_q   <= 6'd32;
			side_y_q   <= 6'd32;
			side_z_q   <= 6'd1;
			pcount_q   <= 11'd1;
			dcount_q   <= 4'd4;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LATTICE_KIND:    lat_kind_q <= cfg_data[2:0];
				REG_BOUNDARY_FIXED:  fixed_q    <= cfg_data[0];
				REG_SIDE_X:          side_x_q   <= cfg_data[5:0];
				REG_SIDE_Y:          side_y_q   <= cfg_data[5:0];
				REG_SIDE_Z:          side_z_q   <= cfg_data[5:0];
				REG_PARTICLE_COUNT:  pcount_q   <= cfg_data;
				REG_DIRECTION_COUNT: dcount_q   <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	function automatic logic [6:0] eff_side(input logic [5:0] s);
		logic [6:0] e;
		e = {1'b0, s};
		if (s == 6'd0) e = 7'd1;
		else if (e > MS) e = MS;
		return e;
	endfunction

	function automatic logic on_lattice(input logic [5:0] c);
		return (c != 6'd0) && ({1'b0, c} <= MS);
	endfunction

	function automatic logic [AXW-1:0] axis_off(input logic [5:0] c);
		logic [5:0] m;
		m = c - 6'd1;
		return m[AXW-1:0];
	endfunction

	// moved coordinate: {outside, coord}
	function automatic logic [6:0] hop_axis(input logic [5:0] c, input logic [1:0] d,
			input logic [6:0] side);
		logic signed [7:0] v;
		logic [6:0] r;
		v = $signed({2'b00, c}) + $signed({{6{d[1]}}, d});
		r = {1'b0, v[5:0]};
		if (d != D0 && (v < 8'sd1 || v > $signed({1'b0, side}))) begin
			r = (d == DP) ? 7'b1_000001 : {1'b1, side[5:0]};
		end
		return r;
	endfunction

	// item
	logic        kind_q;
	logic [9:0]  n_q;
	logic [3:0]  r_q;
	logic [5:0]  px_q, py_q, pz_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= kind;
			n_q    <= particle;
			r_q    <= direction;
			px_q   <= place_x;
			py_q   <= place_y;
			pz_q   <= place_z;
		end
	end

	logic [15:0]   n_wide;
	logic [PW-1:0] n_idx;
	assign n_wide = {6'd0, n_q};
	assign n_idx  = n_wide[PW-1:0];

	// position store {z, y, x}
	logic [17:0] pos_mem [MAX_PARTICLES];
	logic [17:0] pos_rd_q;
	logic        pos_we;
	logic [17:0] res_site;

	always_ff @(posedge clk) begin
		if (pos_we) pos_mem[n_idx] <= res_site;
		if (cmd.pos_rd) pos_rd_q <= pos_mem[n_idx];
	end

	// address / step computation
	logic [5:0]    ox, oy, oz;
	logic [5:0]    step;
	logic [6:0]    hx, hy, hz;
	logic [6:0]    ex, ey, ez;
	logic [16:0]   lim;

	assign {oz, oy, ox} = pos_rd_q;
	assign step = step_lookup(lat_kind_q, r_q);
	assign ex = eff_side(side_x_q);
	assign ey = eff_side(side_y_q);
	assign ez = eff_side(side_z_q);
	assign hx = hop_axis(ox, step[5:4], ex);
	assign hy = hop_axis(oy, step[3:2], ey);
	assign hz = hop_axis(oz, step[1:0], ez);
	assign lim = ({6'd0, pcount_q} < MP) ? {6'd0, pcount_q} : MP;

	logic          bad_part_s2, bad_dir_s2, outside_s2, tgt_ok_s2, oi_ok_s2, same_s2;
	logic [17:0]   tgt_s2;
	logic [IW-1:0] tgt_idx_s2, oi_idx_s2;
	logic [5:0]    step_s2;

	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			bad_part_s2 <= ({7'd0, n_q} >= lim);
			bad_dir_s2  <= (lat_kind_q > LK_LINE) || (r_q >= dcount_q)
				|| ({1'b0, r_q} >= step_count(lat_kind_q));
			outside_s2  <= hx[6] | hy[6] | hz[6];
			step_s2     <= step;
			oi_ok_s2    <= on_lattice(ox) && on_lattice(oy) && on_lattice(oz);
			oi_idx_s2   <= {axis_off(oz), axis_off(oy), axis_off(ox)};
			if (kind_q) begin
				tgt_s2     <= {pz_q, py_q, px_q};
				tgt_ok_s2  <= px_q != 6'd0 && {1'b0, px_q} <= ex
					&& py_q != 6'd0 && {1'b0, py_q} <= ey
					&& pz_q != 6'd0 && {1'b0, pz_q} <= ez;
				tgt_idx_s2 <= {axis_off(pz_q), axis_off(py_q), axis_off(px_q)};
				same_s2    <= 1'b0;
			end else begin
				tgt_s2     <= {hz[5:0], hy[5:0], hx[5:0]};
				tgt_ok_s2  <= on_lattice(hx[5:0]) && on_lattice(hy[5:0])
					&& on_lattice(hz[5:0]);
				tgt_idx_s2 <= {axis_off(hz[5:0]), axis_off(hy[5:0]), axis_off(hx[5:0])};
				same_s2    <= ({hz[5:0], hy[5:0], hx[5:0]} == pos_rd_q);
			end
		end
	end

	// occupancy map, cleared by a sweep after reset
	logic            occ_mem [2**IW];
	logic            occ_rd_q;
	logic [IW-1:0]   clr_addr_q;
	logic            occ_we, occ_wd;
	logic [IW-1:0]   occ_wa;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_addr_q <= '0;
		else if (cmd.clr) clr_addr_q <= clr_addr_q + 1'b1;
	end

	always_ff @(posedge clk) begin
		if (occ_we) occ_mem[occ_wa] <= occ_wd;
		if (cmd.occ_rd) occ_rd_q <= occ_mem[tgt_idx_s2];
	end

	// decision
	logic [2:0]  res_status;
	logic        move_ok, place_ok;

	always_comb begin
		move_ok  = 1'b0;
		place_ok = 1'b0;
		res_site = 18'd0;
		priority if (bad_part_s2) begin
			res_status = ST_BAD_PART;
		end else if (kind_q) begin
			if (!tgt_ok_s2 || occ_rd_q) begin
				res_status = ST_PLACE_FAIL;
			end else begin
				res_status = ST_PLACED;
				res_site   = tgt_s2;
				place_ok   = 1'b1;
			end
		end else begin
			res_site = pos_rd_q;
			if (bad_dir_s2) begin
				res_status = ST_BAD_DIR;
			end else if (outside_s2 && fixed_q) begin
				res_status = ST_WALL;
			end else if (!tgt_ok_s2 || (!same_s2 && occ_rd_q)) begin
				res_status = ST_COLLIDED;
			end else begin
				res_status = ST_MOVED;
				res_site   = tgt_s2;
				move_ok    = 1'b1;
			end
		end
	end

	assign pos_we = cmd.commit && (move_ok || place_ok);

	always_comb begin
		occ_we = 1'b0;
		occ_wa = tgt_idx_s2;
		occ_wd = 1'b1;
		priority if (cmd.clr) begin
			occ_we = 1'b1;
			occ_wa = clr_addr_q;
			occ_wd = 1'b0;
		end else if (cmd.set_new) begin
			occ_we = 1'b1;
		end else if (cmd.commit && place_ok) begin
			occ_we = 1'b1;
		end else if (cmd.commit && move_ok && oi_ok_s2) begin
			occ_we = 1'b1;
			occ_wa = oi_idx_s2;
			occ_wd = 1'b0;
		end
	end

	// displacement of particle 0
	function automatic logic signed [31:0] sat_step(input logic signed [31:0] v,
			input logic [1:0] d);
		logic signed [31:0] r;
		r = v;
		if (d == DP && v != TMAX) r = v + 32'sd1;
		else if (d == DN && v != TMIN) r = v - 32'sd1;
		return r;
	endfunction

	logic signed [31:0] tx_q, ty_q, tz_q;
	logic signed [31:0] tx_n, ty_n, tz_n;
	logic               tag_upd;

	assign tag_upd = move_ok && (n_q == 10'd0);
	assign tx_n = tag_upd ? sat_step(tx_q, step_s2[5:4]) : tx_q;
	assign ty_n = tag_upd ? sat_step(ty_q, step_s2[3:2]) : ty_q;
	assign tz_n = tag_upd ? sat_step(tz_q, step_s2[1:0]) : tz_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_q <= '0;
			ty_q <= '0;
			tz_q <= '0;
		end else if (cmd.commit) begin
			tx_q <= tx_n;
			ty_q <= ty_n;
			tz_q <= tz_n;
		end
	end

	// output register
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.commit) out_valid_q <= 1'b1;
		else if (!out_stall) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status <= res_status;
			{site_z, site_y, site_x} <= res_site;
			tag_dx <= tx_n;
			tag_dy <= ty_n;
			tag_dz <= tz_n;
		end
	end

	assign out_valid    = out_valid_q;
	assign sts.out_free = !out_valid_q || !out_stall;
	assign sts.need_set = move_ok;
	assign sts.clr_last = (clr_addr_q == {IW{1'b1}});

endmodule

// ===== src/lattice_exclusion_hop.sv =====
// Exclusion-process hops of labelled particles on a 1-based lattice.
// Input channel (in_valid / in_stall) carries one item: a place of a particle
// on a free site, or a move of one hop along the step table of lattice_kind.
// Output channel (out_valid / out_stall) returns one result per item: status,
// the particle's site and the displacement of particle 0.
// Configuration is written through cfg_we / cfg_index / cfg_data while idle.
// After the transfer the result register loads at the end of these steps:
// position read, step and address, occupancy read, decision.
// No new item is taken before the last has passed these steps; a successful
// hop adds a step, a second write through the single occupancy memory port.
// The next item is accepted once the block is back in idle, even while the
// previous result still waits; a stalled output holds the block in its
// decision step until the result register frees.
// After reset a sweep clears all 2**(3*clog2(MAX_SIDE)) occupancy map addresses
// (32768 by default); in_stall stays high until it ends.
// The position store is not reset; moving a never placed particle is illegal.
module lattice_exclusion_hop #(
	parameter int MAX_SIDE      = 32,
	parameter int MAX_PARTICLES = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [10:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               kind,
	input  logic [9:0]         particle,
	input  logic [3:0]         direction,
	input  logic [5:0]         place_x,
	input  logic [5:0]         place_y,
	input  logic [5:0]         place_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         status,
	output logic [5:0]         site_x,
	output logic [5:0]         site_y,
	output logic [5:0]         site_z,
	output logic signed [31:0] tag_dx,
	output logic signed [31:0] tag_dy,
	output logic signed [31:0] tag_dz
);
	import leh_pkg::*;

	cmd_t cmd;
	sts_t sts;

	leh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	leh_datapath #(
		.MAX_SIDE      (MAX_SIDE),
		.MAX_PARTICLES (MAX_PARTICLES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.kind      (kind),
		.particle  (particle),
		.direction (direction),
		.place_x   (place_x),
		.place_y   (place_y),
		.place_z   (place_z),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.site_x    (site_x),
		.site_y    (site_y),
		.site_z    (site_z),
		.tag_dx    (tag_dx),
		.tag_dy    (tag_dy),
		.tag_dz    (tag_dz)
	);

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb;
	import leh_pkg::*;

	localparam int SIDE_MAX   = 32;
	localparam int LABELS     = 1024;
	localparam int LIMIT      = 900000;
	localparam logic [2:0] LK_UNDEF = 3'd7;

	// hop table per lattice kind, {dx, dy, dz}
	localparam int HOPS [5][12][3] = '{
		'{'{1,0,0},'{-1,0,0},'{0,1,0},'{0,-1,0},'{0,0,1},'{0,0,-1},
		  '{0,0,0},'{0,0,0},'{0,0,0},'{0,0,0},'{0,0,0},'{0,0,0}},
		'{'{1,0,0},'{-1,0,0},'{0,1,0},'{0,-1,0},'{-1,1,0},'{1,-1,0},
		  '{0,0,0},'{0,0,0},'{0,0,0},'{0,0,0},'{0,0,0},'{0,0,0}},
		'{'{1,1,1},'{-1,1,1},'{1,-1,1},'{1,1,-1},'{1,-1,-1},'{-1,1,-1},
		  '{-1,-1,1},'{-1,-1,-1},'{0,0,0},'{0,0,0},'{0,0,0},'{0,0,0}},
		'{'{1,1,0},'{-1,1,0},'{1,-1,0},'{-1,-1,0},'{1,0,1},'{1,0,-1},
		  '{-1,0,1},'{-1,0,-1},'{0,1,1},'{0,1,-1},'{0,-1,1},'{0,-1,-1}},
		'{'{1,0,0},'{-1,0,0},'{0,0,0},'{0,0,0},'{0,0,0},'{0,0,0},
		  '{0,0,0},'{0,0,0},'{0,0,0},'{0,0,0},'{0,0,0},'{0,0,0}}
	};
	localparam int HOP_COUNT [5] = '{6, 6, 8, 12, 2};

	typedef struct {
		status_t            st;
		logic [5:0]         sx, sy, sz;
		logic signed [31:0] dx, dy, dz;
	} hop_result_t;

	class hop_tracker;
		logic [2:0]  lk;
		logic        fixed_walls;
		logic [5:0]  side_raw [3];
		logic [10:0] pcount;
		logic [3:0]  dcount;
		logic [5:0]  pos [LABELS][3];
		bit          placed [LABELS];
		int          placed_list [$];
		bit          occ [SIDE_MAX*SIDE_MAX*SIDE_MAX];
		int          tag [3];
		hop_result_t expected_hops [$];
		int          fails;
		int          checked;

		function new();
			lk = LK_SQUARE; fixed_walls = 0;
			side_raw = '{6'd32, 6'd32, 6'd1};
			pcount = 11'd1; dcount = 4'd4;
			tag = '{0, 0, 0};
			fails = 0; checked = 0;
		endfunction

		function void set_reg(reg_index_t idx, logic [10:0] v);
			case (idx)
				REG_LATTICE_KIND:    lk = v[2:0];
				REG_BOUNDARY_FIXED:  fixed_walls = v[0];
				REG_SIDE_X:          side_raw[0] = v[5:0];
				REG_SIDE_Y:          side_raw[1] = v[5:0];
				REG_SIDE_Z:          side_raw[2] = v[5:0];
				REG_PARTICLE_COUNT:  pcount = v;
				REG_DIRECTION_COUNT: dcount = v[3:0];
				default: ;
			endcase
		endfunction

		function int side(int a);
			if (side_raw[a] < 1) return 1;
			if (side_raw[a] > SIDE_MAX) return SIDE_MAX;
			return side_raw[a];
		endfunction

		function int label_limit();
			return (pcount < LABELS) ? pcount : LABELS;
		endfunction

		function int hop_limit();
			int n;
			n = (lk > LK_LINE) ? 0 : HOP_COUNT[lk];
			return (dcount < n) ? dcount : n;
		endfunction

		function int site_of(int c [3]);
			foreach (c[a]) if (c[a] < 1 || c[a] > SIDE_MAX) return -1;
			return (c[0]-1) + SIDE_MAX*((c[1]-1) + SIDE_MAX*(c[2]-1));
		endfunction

		function int sat(int v, int d);
			longint r;
			r = longint'(v) + d;
			if (r > 64'sd2147483647) return 32'sh7fffffff;
			if (r < -64'sd2147483648) return 32'sh80000000;
			return int'(r);
		endfunction

		function void note_transfer(logic k, logic [9:0] n, logic [3:0] r,
		                            logic [5:0] px, logic [5:0] py, logic [5:0] pz);
			hop_result_t e;
			int c [3], old [3], nw [3], d [3];
			int oi, ni, v;
			bit ok, outside;
			c = '{0, 0, 0};
			if (n >= label_limit()) begin
				e.st = ST_BAD_PART;
			end else if (k) begin
				c = '{px, py, pz};
				ok = 1;
				foreach (c[a]) if (c[a] < 1 || c[a] > side(a)) ok = 0;
				if (!ok || occ[site_of(c)]) begin
					e.st = ST_PLACE_FAIL;
					c = '{0, 0, 0};
				end else begin
					occ[site_of(c)] = 1;
					foreach (c[a]) pos[n][a] = c[a];
					if (!placed[n]) placed_list.push_back(n);
					placed[n] = 1;
					e.st = ST_PLACED;
				end
			end else begin
				foreach (old[a]) old[a] = pos[n][a];
				c = old;
				if (lk > LK_LINE || r >= dcount || r >= HOP_COUNT[lk]) begin
					e.st = ST_BAD_DIR;
				end else begin
					outside = 0;
					for (int a = 0; a < 3; a++) begin
						d[a] = HOPS[lk][r][a];
						v = old[a] + d[a];
						if (d[a] != 0 && (v < 1 || v > side(a))) begin
							outside = 1;
							v = (d[a] > 0) ? 1 : side(a);
						end
						nw[a] = v;
					end
					oi = site_of(old);
					ni = site_of(nw);
					if (outside && fixed_walls) begin
						e.st = ST_WALL;
					end else if (ni < 0 || (ni != oi && occ[ni])) begin
						e.st = ST_COLLIDED;
					end else begin
						if (oi >= 0) occ[oi] = 0;
						occ[ni] = 1;
						foreach (nw[a]) pos[n][a] = nw[a];
						c = nw;
						if (n == 0) foreach (tag[a]) tag[a] = sat(tag[a], d[a]);
						e.st = ST_MOVED;
					end
				end
			end
			e.sx = c[0]; e.sy = c[1]; e.sz = c[2];
			e.dx = tag[0]; e.dy = tag[1]; e.dz = tag[2];
			expected_hops.push_back(e);
		endfunction

		function void check_result(hop_result_t got);
			hop_result_t e;
			checked++;
			if (expected_hops.size() == 0) begin
				$error("result with nothing outstanding: status %0d", got.st);
				fails++;
				return;
			end
			e = expected_hops.pop_front();
			if (got.st !== e.st) begin
				$error("status: expected %0d, got %0d", e.st, got.st); fails++;
			end
			if (got.sx !== e.sx) begin
				$error("site_x: expected %0d, got %0d", e.sx, got.sx); fails++;
			end
			if (got.sy !== e.sy) begin
				$error("site_y: expected %0d, got %0d", e.sy, got.sy); fails++;
			end
			if (got.sz !== e.sz) begin
				$error("site_z: expected %0d, got %0d", e.sz, got.sz); fails++;
			end
			if (got.dx !== e.dx) begin
				$error("tag_dx: expected %0d, got %0d", e.dx, got.dx); fails++;
			end
			if (got.dy !== e.dy) begin
				$error("tag_dy: expected %0d, got %0d", e.dy, got.dy); fails++;
			end
			if (got.dz !== e.dz) begin
				$error("tag_dz: expected %0d, got %0d", e.dz, got.dz); fails++;
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [10:0] cfg_data;
	logic in_valid, in_stall, kind;
	logic [9:0] particle;
	logic [3:0] direction;
	logic [5:0] place_x, place_y, place_z;
	logic out_valid, out_stall;
	logic [2:0] status;
	logic [5:0] site_x, site_y, site_z;
	logic signed [31:0] tag_dx, tag_dy, tag_dz;

	hop_tracker tracker;
	int idle_in, idle_out;
	int cycles, items_sent, settings;

	lattice_exclusion_hop u_dut (.*);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		hop_result_t got;
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
		if (arst_n && out_valid && !out_stall) begin
			got.st = status_t'(status);
			got.sx = site_x; got.sy = site_y; got.sz = site_z;
			got.dx = tag_dx; got.dy = tag_dy; got.dz = tag_dz;
			tracker.check_result(got);
		end
		out_stall <= ($urandom_range(99) < idle_out);
	end

	task automatic send(logic k, logic [9:0] n, logic [3:0] r,
	                    logic [5:0] px, logic [5:0] py, logic [5:0] pz);
		if ($urandom_range(99) < idle_in) begin
			in_valid <= 0;
			do @(posedge clk); while ($urandom_range(99) < idle_in);
		end
		in_valid <= 1;
		kind <= k; particle <= n; direction <= r;
		place_x <= px; place_y <= py; place_z <= pz;
		do @(posedge clk); while (in_stall);
		tracker.note_transfer(k, n, r, px, py, pz);
		items_sent++;
	endtask

	// wait until every transfer is answered, then let the pipeline settle
	task automatic drain();
		in_valid <= 0;
		while (tracker.expected_hops.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic configure(logic [2:0] lk, logic fw, logic [5:0] sx, logic [5:0] sy,
	                         logic [5:0] sz, logic [10:0] pc, logic [3:0] dc);
		logic [10:0] vals [7];
		vals = '{11'(lk), 11'(fw), 11'(sx), 11'(sy), 11'(sz), pc, 11'(dc)};
		for (int i = 0; i < 7; i++) begin
			cfg_we <= 1;
			cfg_index <= 3'(i);
			cfg_data <= vals[i];
			@(posedge clk);
			tracker.set_reg(reg_index_t'(i), vals[i]);
		end
		cfg_we <= 0;
		@(posedge clk);
		settings++;
	endtask

	function automatic logic [5:0] pick_coord(int a);
		int s, p;
		s = tracker.side(a);
		p = $urandom_range(99);
		if (p < 85) return 6'($urandom_range(s, 1));
		if (p < 95) return 6'($urandom_range(s + 1, 0));
		return 6'($urandom_range(63, 0));
	endfunction

	task automatic random_item();
		int lim, hl, n, tries;
		logic [3:0] r;
		lim = tracker.label_limit();
		n = -1;
		if ($urandom_range(99) < 65) begin
			if (lim < LABELS && $urandom_range(99) < 10) begin
				n = $urandom_range(LABELS - 1, lim);
			end else begin
				for (tries = 0; tries < 20 && n < 0; tries++) begin
					if (tracker.placed_list.size() == 0) break;
					n = tracker.placed_list[$urandom_range(tracker.placed_list.size() - 1)];
					if (n >= lim) n = -1;
				end
			end
		end
		if (n >= 0) begin
			hl = tracker.hop_limit();
			if (hl > 0 && $urandom_range(99) < 85) r = 4'($urandom_range(hl - 1));
			else r = 4'($urandom_range(15));
			send(0, 10'(n), r, 6'($urandom), 6'($urandom), 6'($urandom));
		end else begin
			if ($urandom_range(99) < 92) n = $urandom_range(lim - 1);
			else n = $urandom_range(LABELS - 1);
			send(1, 10'(n), 4'($urandom), pick_coord(0), pick_coord(1), pick_coord(2));
		end
	endtask

	task automatic random_phase(logic [2:0] lk, logic fw, logic [5:0] sx, logic [5:0] sy,
	                            logic [5:0] sz, logic [10:0] pc, logic [3:0] dc, int count);
		configure(lk, fw, sx, sy, sz, pc, dc);
		repeat (count) random_item();
		drain();
	endtask

	initial begin
		tracker = new();
		arst_n = 0; cfg_we = 0; cfg_index = '0; cfg_data = '0;
		in_valid = 0; kind = 0; particle = '0; direction = '0;
		place_x = 6'd1; place_y = 6'd1; place_z = 6'd1;
		out_stall = 0;
		cycles = 0; items_sent = 0; settings = 0;
		idle_in = 22; idle_out = 66;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: placement rules, wraps, walls, collision, own-site wrap
		configure(LK_SQUARE, 0, 6'd3, 6'd3, 6'd3, 11'd4, 4'd15);
		send(1, 10'd0, 4'd0, 6'd1, 6'd1, 6'd1);
		send(1, 10'd1, 4'd0, 6'd1, 6'd1, 6'd1);
		send(1, 10'd1, 4'd0, 6'd4, 6'd1, 6'd1);
		send(1, 10'd1, 4'd0, 6'd0, 6'd1, 6'd1);
		send(1, 10'd1, 4'd15, 6'd3, 6'd3, 6'd3);
		send(1, 10'd1023, 4'd0, 6'd63, 6'd63, 6'd63);
		send(0, 10'd7, 4'd0, 6'd0, 6'd0, 6'd0);
		send(0, 10'd0, 4'd1, 6'd0, 6'd0, 6'd0);
		send(0, 10'd0, 4'd6, 6'd0, 6'd0, 6'd0);
		send(0, 10'd0, 4'd0, 6'd0, 6'd0, 6'd0);
		send(0, 10'd0, 4'd5, 6'd0, 6'd0, 6'd0);
		send(0, 10'd0, 4'd1, 6'd0, 6'd0, 6'd0);
		send(0, 10'd0, 4'd3, 6'd0, 6'd0, 6'd0);
		drain();
		configure(LK_SQUARE, 1, 6'd3, 6'd3, 6'd3, 11'd4, 4'd6);
		send(0, 10'd0, 4'd0, 6'd0, 6'd0, 6'd0);
		send(0, 10'd1, 4'd4, 6'd0, 6'd0, 6'd0);
		drain();
		configure(LK_SQUARE, 0, 6'd3, 6'd1, 6'd3, 11'd4, 4'd6);
		send(0, 10'd0, 4'd2, 6'd0, 6'd0, 6'd0);
		drain();
		configure(LK_UNDEF, 0, 6'd3, 6'd3, 6'd3, 11'd4, 4'd15);
		send(0, 10'd0, 4'd0, 6'd0, 6'd0, 6'd0);
		drain();
		configure(LK_BCC, 0, 6'd3, 6'd3, 6'd3, 11'd4, 4'd0);
		send(0, 10'd0, 4'd0, 6'd0, 6'd0, 6'd0);
		drain();

		random_phase(LK_SQUARE, 0, 6'd4, 6'd4, 6'd2, 11'd16, 4'd6, 100);
		random_phase(LK_HONEYCOMB, 1, 6'd5, 6'd5, 6'd1, 11'd8, 4'd6, 100);
		random_phase(LK_BCC, 0, 6'd3, 6'd3, 6'd3, 11'd1024, 4'd8, 100);
		idle_in = 66; idle_out = 22;
		random_phase(LK_FCC, 1, 6'd32, 6'd32, 6'd32, 11'd2047, 4'd12, 100);
		random_phase(LK_LINE, 0, 6'd6, 6'd1, 6'd1, 11'd6, 4'd15, 100);
		random_phase(LK_UNDEF, 1, 6'd0, 6'd63, 6'd2, 11'd3, 4'd9, 40);
		idle_in = 0; idle_out = 0;
		random_phase(LK_FCC, 0, 6'd2, 6'd2, 6'd2, 11'd12, 4'd12, 100);
		random_phase(LK_BCC, 1, 6'd0, 6'd2, 6'd33, 11'd1, 4'd1, 60);
		random_phase(LK_SQUARE, 1, 6'd1, 6'd1, 6'd1, 11'd0, 4'd0, 20);
		random_phase(LK_HONEYCOMB, 0, 6'd8, 6'd3, 6'd1, 11'd1024, 4'd6, 80);

		$display("%0d transfers over %0d register settings, %0d results checked",
		         items_sent, settings, tracker.checked);
		$display("all lattice kinds, both boundaries, sides from 0 to 63 and label limits");
		if (tracker.fails == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
